>>> sv/vppg_pkg.sv
`default_nettype none
package vppg_pkg;

  localparam int COORD_W = 12;
  localparam int POS_W   = 13;
  localparam int VAL_W   = 26;
  localparam int NPOINTS = 4;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [1:0] OPC_LOAD   = 2'd0;
  localparam logic [1:0] OPC_START  = 2'd1;
  localparam logic [1:0] OPC_STEP   = 2'd2;
  localparam logic [1:0] OPC_UNUSED = 2'd3;

  localparam logic [2:0] KIND_LINE    = 3'd0;
  localparam logic [2:0] KIND_ARC     = 3'd1;
  localparam logic [2:0] KIND_POINT   = 3'd2;
  localparam logic [2:0] KIND_QUAD    = 3'd3;
  localparam logic [2:0] KIND_CUBIC   = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd7;

  localparam logic [6:0] PC_LINE  = 7'd0;
  localparam logic [6:0] PC_QUAD  = 7'd12;
  localparam logic [6:0] PC_CUBIC = 7'd34;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RUN   = 6'b000010,
    S_DIV   = 6'b000100,
    S_ARC_X = 6'b001000,
    S_ARC_Y = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    OP_SET, OP_MUL, OP_DIV, OP_ACC, OP_GET, OP_PUT, OP_END
  } mop_e;

  typedef enum logic [3:0] {
    SRC_ONE, SRC_TWO, SRC_THREE, SRC_A, SRC_I, SRC_P0, SRC_P1, SRC_P2, SRC_P3
  } msrc_e;

  typedef struct packed {
    mop_e  op;
    msrc_e src;
  } mword_t;

  // Sequencer program: one coordinate of a line, quadratic or cubic point.
  // The value register is scaled by multiplies and divisions by the span,
  // and each finished term is added into the accumulator.
  function automatic mword_t prog_word(input logic [6:0] pc);
    mword_t w;
    w = '{OP_END, SRC_ONE};
    unique case (pc)
      // Line: ((r - i) * p0 + i * p1) / r
      7'd0:  w = '{OP_SET, SRC_ONE};
      7'd1:  w = '{OP_MUL, SRC_A};
      7'd2:  w = '{OP_MUL, SRC_P0};
      7'd3:  w = '{OP_ACC, SRC_ONE};
      7'd4:  w = '{OP_SET, SRC_ONE};
      7'd5:  w = '{OP_MUL, SRC_I};
      7'd6:  w = '{OP_MUL, SRC_P1};
      7'd7:  w = '{OP_ACC, SRC_ONE};
      7'd8:  w = '{OP_GET, SRC_ONE};
      7'd9:  w = '{OP_DIV, SRC_ONE};
      7'd10: w = '{OP_PUT, SRC_ONE};
      7'd11: w = '{OP_END, SRC_ONE};
      // Quadratic
      7'd12: w = '{OP_SET, SRC_ONE};
      7'd13: w = '{OP_MUL, SRC_A};
      7'd14: w = '{OP_MUL, SRC_A};
      7'd15: w = '{OP_DIV, SRC_ONE};
      7'd16: w = '{OP_MUL, SRC_P0};
      7'd17: w = '{OP_DIV, SRC_ONE};
      7'd18: w = '{OP_ACC, SRC_ONE};
      7'd19: w = '{OP_SET, SRC_TWO};
      7'd20: w = '{OP_MUL, SRC_A};
      7'd21: w = '{OP_MUL, SRC_P1};
      7'd22: w = '{OP_DIV, SRC_ONE};
      7'd23: w = '{OP_MUL, SRC_I};
      7'd24: w = '{OP_DIV, SRC_ONE};
      7'd25: w = '{OP_ACC, SRC_ONE};
      7'd26: w = '{OP_SET, SRC_ONE};
      7'd27: w = '{OP_MUL, SRC_I};
      7'd28: w = '{OP_MUL, SRC_P2};
      7'd29: w = '{OP_DIV, SRC_ONE};
      7'd30: w = '{OP_MUL, SRC_I};
      7'd31: w = '{OP_DIV, SRC_ONE};
      7'd32: w = '{OP_ACC, SRC_ONE};
      7'd33: w = '{OP_END, SRC_ONE};
      // Cubic
      7'd34: w = '{OP_SET, SRC_ONE};
      7'd35: w = '{OP_MUL, SRC_A};
      7'd36: w = '{OP_MUL, SRC_A};
      7'd37: w = '{OP_DIV, SRC_ONE};
      7'd38: w = '{OP_MUL, SRC_P0};
      7'd39: w = '{OP_DIV, SRC_ONE};
      7'd40: w = '{OP_MUL, SRC_A};
      7'd41: w = '{OP_DIV, SRC_ONE};
      7'd42: w = '{OP_ACC, SRC_ONE};
      7'd43: w = '{OP_SET, SRC_THREE};
      7'd44: w = '{OP_MUL, SRC_A};
      7'd45: w = '{OP_MUL, SRC_P1};
      7'd46: w = '{OP_DIV, SRC_ONE};
      7'd47: w = '{OP_MUL, SRC_A};
      7'd48: w = '{OP_DIV, SRC_ONE};
      7'd49: w = '{OP_MUL, SRC_I};
      7'd50: w = '{OP_DIV, SRC_ONE};
      7'd51: w = '{OP_ACC, SRC_ONE};
      7'd52: w = '{OP_SET, SRC_THREE};
      7'd53: w = '{OP_MUL, SRC_A};
      7'd54: w = '{OP_MUL, SRC_P2};
      7'd55: w = '{OP_DIV, SRC_ONE};
      7'd56: w = '{OP_MUL, SRC_I};
      7'd57: w = '{OP_DIV, SRC_ONE};
      7'd58: w = '{OP_MUL, SRC_I};
      7'd59: w = '{OP_DIV, SRC_ONE};
      7'd60: w = '{OP_ACC, SRC_ONE};
      7'd61: w = '{OP_SET, SRC_ONE};
      7'd62: w = '{OP_MUL, SRC_I};
      7'd63: w = '{OP_MUL, SRC_P3};
      7'd64: w = '{OP_DIV, SRC_ONE};
      7'd65: w = '{OP_MUL, SRC_I};
      7'd66: w = '{OP_DIV, SRC_ONE};
      7'd67: w = '{OP_MUL, SRC_I};
      7'd68: w = '{OP_DIV, SRC_ONE};
      7'd69: w = '{OP_ACC, SRC_ONE};
      default: w = '{OP_END, SRC_ONE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> sv/vector_path_point_generator.sv
`default_nettype none
// Vector path point generator. Load words fill four control points, a start word picks a
// line, arc, point, quadratic or cubic Bezier, and each step word returns the next point as
// two 8-bit DAC levels with tlast on the final point. A point, or a line or curve of zero
// span, answers a step directly from the first control point, and an arc point uses one
// signed multiplier for cosine then sine. Line and curve points run a small microprogram
// twice (x, then y) over one 14x12 multiplier and a restoring divider that retires one
// quotient bit per cycle. The block takes no new word while a step is being worked out.
module vector_path_point_generator
  import vppg_pkg::*;
#(
  parameter int STEP_STRIDE  = 16,
  parameter int SINE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // kind[2:0], point_index[4:3], px[16:5], py[28:17], radius[40:29],
  // first_angle[51:41], final_angle[62:52], dwell_us[78:63], zero[79]
  input  wire logic [79:0] s_axis_tdata_i,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // dac_x[7:0], dac_y[15:8], hold_us[31:16]
  output logic [31:0]      m_axis_tdata_o,
  output logic             m_axis_tlast_o
);

  localparam int IdxW = $clog2(SINE_ENTRIES);

  // Quarter-wave Taylor series in Q30, rounded to Q15 and signed by quadrant.
  function automatic logic signed [15:0] sine_entry(input int k);
    logic [63:0] f, quad, rem, x, x2, t, q;
    logic signed [63:0] sum;
    logic signed [15:0] v;
    f    = 64'(4 * k);
    quad = f / SINE_ENTRIES;
    rem  = f % SINE_ENTRIES;
    if (quad[0]) rem = 64'(SINE_ENTRIES) - rem;
    x   = rem * HALF_PI_Q30 / SINE_ENTRIES;
    x2  = (x * x) >> 30;
    t   = x;
    sum = signed'(x);
    t   = ((t * x2) >> 30) / 6;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 20;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 42;
    sum = sum - signed'(t);
    t   = ((t * x2) >> 30) / 72;
    sum = sum + signed'(t);
    t   = ((t * x2) >> 30) / 110;
    sum = sum - signed'(t);
    if (sum < 0) sum = 0;
    q = (64'(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    v = signed'(q[15:0]);
    if (quad >= 64'd2) v = -v;
    return v;
  endfunction

  logic signed [15:0] sine_rom [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_sine
    assign sine_rom[k] = sine_entry(k);
  end

  // Input fields.
  logic [1:0]         in_op;
  logic [2:0]         in_kind;
  logic [1:0]         in_index;
  logic [11:0]        in_px, in_py, in_radius;
  logic signed [10:0] in_start, in_end;
  logic [15:0]        in_dwell;
  logic               in_fire;

  assign in_op    = s_axis_tuser_i;
  assign in_kind  = s_axis_tdata_i[2:0];
  assign in_index = s_axis_tdata_i[4:3];
  assign in_px    = s_axis_tdata_i[16:5];
  assign in_py    = s_axis_tdata_i[28:17];
  assign in_radius = s_axis_tdata_i[40:29];
  assign in_start = signed'(s_axis_tdata_i[51:41]);
  assign in_end   = signed'(s_axis_tdata_i[62:52]);
  assign in_dwell = s_axis_tdata_i[78:63];

  // Control state.
  state_e             state_q, state_d;
  logic               busy_q, busy_d;
  logic [2:0]         kind_q, kind_d;
  logic [11:0]        radius_q, radius_d;
  logic signed [10:0] ang_now_q, ang_now_d, ang_last_q, ang_last_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [11:0]        span_q, span_d;
  logic [15:0]        dwell_q, dwell_d;
  logic [6:0]         pc_q, pc_d;
  logic               coord_q, coord_d;
  logic [4:0]         cnt_q, cnt_d;
  logic               mvalid_q, mvalid_d;

  // Payload.
  logic [11:0]      ctrl_x_q [NPOINTS];
  logic [11:0]      ctrl_x_d [NPOINTS];
  logic [11:0]      ctrl_y_q [NPOINTS];
  logic [11:0]      ctrl_y_d [NPOINTS];
  logic [VAL_W-1:0] v_q, v_d, acc_q, acc_d;
  logic [11:0]      rem_q, rem_d;
  logic [7:0]       resx_q, resx_d, resy_q, resy_d;
  logic [15:0]      reshold_q, reshold_d;
  logic             reslast_q, reslast_d;
  logic [7:0]       mx_q, mx_d, my_q, my_d;
  logic [15:0]      mhold_q, mhold_d;
  logic             mlast_q, mlast_d;

  // Span of a new primitive from the first to its far control point.
  logic [1:0]  far;
  logic [11:0] dx, dy, span_new;

  always_comb begin
    unique case (in_kind)
      KIND_LINE:  far = 2'd1;
      KIND_QUAD:  far = 2'd2;
      KIND_CUBIC: far = 2'd3;
      default:    far = 2'd0;
    endcase
    dx = (ctrl_x_q[far] > ctrl_x_q[0]) ? ctrl_x_q[far] - ctrl_x_q[0]
                                       : ctrl_x_q[0] - ctrl_x_q[far];
    dy = (ctrl_y_q[far] > ctrl_y_q[0]) ? ctrl_y_q[far] - ctrl_y_q[0]
                                       : ctrl_y_q[0] - ctrl_y_q[far];
    span_new = (dx > dy) ? dx : dy;
  end

  // Shared multiply and divide datapath.
  mword_t           word;
  logic [11:0]      opnd;
  logic [VAL_W-1:0] mul_p;
  logic [12:0]      rem_sh;
  logic             q_bit;
  logic [6:0]       pc_start;

  assign word = prog_word(pc_q);

  always_comb begin
    unique case (word.src)
      SRC_ONE:   opnd = 12'd1;
      SRC_TWO:   opnd = 12'd2;
      SRC_THREE: opnd = 12'd3;
      SRC_A:     opnd = span_q - pos_q[11:0];
      SRC_I:     opnd = pos_q[11:0];
      SRC_P0:    opnd = coord_q ? ctrl_y_q[0] : ctrl_x_q[0];
      SRC_P1:    opnd = coord_q ? ctrl_y_q[1] : ctrl_x_q[1];
      SRC_P2:    opnd = coord_q ? ctrl_y_q[2] : ctrl_x_q[2];
      SRC_P3:    opnd = coord_q ? ctrl_y_q[3] : ctrl_x_q[3];
      default:   opnd = 12'd0;
    endcase
  end

  assign mul_p  = VAL_W'(v_q[13:0]) * VAL_W'(opnd);
  assign rem_sh = {rem_q, v_q[VAL_W-1]};
  assign q_bit  = rem_sh >= {1'b0, span_q};

  always_comb begin
    unique case (kind_q)
      KIND_QUAD:  pc_start = PC_QUAD;
      KIND_CUBIC: pc_start = PC_CUBIC;
      default:    pc_start = PC_LINE;
    endcase
  end

  // Arc point: centre + radius * table / 32768, truncated toward zero.
  logic [7:0]          cos_m;
  logic [31:0]         sin_t, cos_t;
  logic signed [15:0]  trig;
  logic signed [28:0]  arc_p;
  logic [11:0]         centre;
  logic signed [30:0]  arc_sum, arc_q;
  logic [15:0]         arc_w, arc_adj;
  logic [7:0]          arc_dac;

  assign cos_m = ang_now_q[7:0] + 8'd64;
  assign sin_t = (32'(ang_now_q[7:0]) * SINE_ENTRIES) >> 8;
  assign cos_t = (32'(cos_m) * SINE_ENTRIES) >> 8;

  always_comb begin
    trig    = (state_q == S_ARC_X) ? sine_rom[cos_t[IdxW-1:0]] : sine_rom[sin_t[IdxW-1:0]];
    centre  = (state_q == S_ARC_X) ? ctrl_x_q[0] : ctrl_y_q[0];
    arc_p   = signed'({1'b0, radius_q}) * trig;
    arc_sum = 31'(arc_p) + signed'({4'd0, centre, 15'd0});
    arc_q   = arc_sum[30] ? (arc_sum + 31'sd32767) >>> 15 : arc_sum >>> 15;
    arc_w   = arc_q[15:0];
    arc_adj = arc_w[15] ? arc_w + 16'd15 : arc_w;
    arc_dac = arc_adj[11:4];
  end

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    kind_d     = kind_q;
    radius_d   = radius_q;
    ang_now_d  = ang_now_q;
    ang_last_d = ang_last_q;
    pos_d      = pos_q;
    span_d     = span_q;
    dwell_d    = dwell_q;
    pc_d       = pc_q;
    coord_d    = coord_q;
    cnt_d      = cnt_q;
    ctrl_x_d   = ctrl_x_q;
    ctrl_y_d   = ctrl_y_q;
    v_d        = v_q;
    acc_d      = acc_q;
    rem_d      = rem_q;
    resx_d     = resx_q;
    resy_d     = resy_q;
    reshold_d  = reshold_q;
    reslast_d  = reslast_q;
    mx_d       = mx_q;
    my_d       = my_q;
    mhold_d    = mhold_q;
    mlast_d    = mlast_q;
    mvalid_d   = mvalid_q && !m_axis_tready_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OPC_LOAD: begin
              ctrl_x_d[in_index] = in_px;
              ctrl_y_d[in_index] = in_py;
            end
            OPC_START: begin
              kind_d     = in_kind;
              radius_d   = in_radius;
              ang_now_d  = in_start;
              ang_last_d = in_end;
              dwell_d    = in_dwell;
              pos_d      = '0;
              span_d     = '0;
              busy_d     = 1'b1;
              if (in_kind == KIND_LINE || in_kind == KIND_QUAD || in_kind == KIND_CUBIC) begin
                span_d = span_new;
              end else if (in_kind == KIND_ARC) begin
                busy_d = (in_start <= in_end);
              end else if (in_kind != KIND_POINT) begin
                busy_d = 1'b0;
              end
            end
            OPC_STEP: begin
              if (busy_q) begin
                if (kind_q == KIND_ARC) begin
                  state_d = S_ARC_X;
                end else if (kind_q == KIND_POINT || span_q == 12'd0) begin
                  // A point, or a line or curve of zero span, shows the first point once.
                  resx_d    = ctrl_x_q[0][11:4];
                  resy_d    = ctrl_y_q[0][11:4];
                  reshold_d = (kind_q == KIND_POINT) ? dwell_q : 16'd0;
                  reslast_d = 1'b1;
                  busy_d    = 1'b0;
                  state_d   = S_DONE;
                end else begin
                  pc_d    = pc_start;
                  coord_d = 1'b0;
                  acc_d   = '0;
                  state_d = S_RUN;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        pc_d = pc_q + 7'd1;
        unique case (word.op)
          OP_SET: v_d = VAL_W'(opnd);
          OP_MUL: v_d = mul_p;
          OP_ACC: acc_d = acc_q + v_q;
          OP_GET: v_d = acc_q;
          OP_PUT: acc_d = v_q;
          OP_DIV: begin
            rem_d   = '0;
            cnt_d   = 5'(VAL_W - 1);
            state_d = S_DIV;
          end
          OP_END: begin
            if (!coord_q) begin
              resx_d  = acc_q[11:4];
              coord_d = 1'b1;
              pc_d    = pc_start;
              acc_d   = '0;
            end else begin
              resy_d    = acc_q[11:4];
              reshold_d = 16'd0;
              reslast_d = (pos_q + POS_W'(STEP_STRIDE)) > {1'b0, span_q};
              pos_d     = pos_q + POS_W'(STEP_STRIDE);
              if ((pos_q + POS_W'(STEP_STRIDE)) > {1'b0, span_q}) busy_d = 1'b0;
              state_d = S_DONE;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        rem_d = q_bit ? 12'(rem_sh - {1'b0, span_q}) : rem_sh[11:0];
        v_d   = {v_q[VAL_W-2:0], q_bit};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd0) state_d = S_RUN;
      end
      S_ARC_X: begin
        resx_d  = arc_dac;
        state_d = S_ARC_Y;
      end
      S_ARC_Y: begin
        resy_d    = arc_dac;
        reshold_d = 16'd0;
        reslast_d = (ang_now_q >= ang_last_q);
        if (ang_now_q >= ang_last_q) begin
          busy_d = 1'b0;
        end else begin
          ang_now_d = ang_now_q + 11'sd1;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mx_d     = resx_q;
          my_d     = resy_q;
          mhold_d  = reshold_q;
          mlast_d  = reslast_q;
          mvalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_q     <= 1'b0;
      kind_q     <= '0;
      radius_q   <= '0;
      ang_now_q  <= '0;
      ang_last_q <= '0;
      pos_q      <= '0;
      span_q     <= '0;
      dwell_q    <= '0;
      pc_q       <= '0;
      coord_q    <= 1'b0;
      cnt_q      <= '0;
      mvalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      busy_q     <= busy_d;
      kind_q     <= kind_d;
      radius_q   <= radius_d;
      ang_now_q  <= ang_now_d;
      ang_last_q <= ang_last_d;
      pos_q      <= pos_d;
      span_q     <= span_d;
      dwell_q    <= dwell_d;
      pc_q       <= pc_d;
      coord_q    <= coord_d;
      cnt_q      <= cnt_d;
      mvalid_q   <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_x_q  <= ctrl_x_d;
    ctrl_y_q  <= ctrl_y_d;
    v_q       <= v_d;
    acc_q     <= acc_d;
    rem_q     <= rem_d;
    resx_q    <= resx_d;
    resy_q    <= resy_d;
    reshold_q <= reshold_d;
    reslast_q <= reslast_d;
    mx_q      <= mx_d;
    my_q      <= my_d;
    mhold_q   <= mhold_d;
    mlast_q   <= mlast_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {mhold_q, my_q, mx_q};
  assign m_axis_tlast_o  = mlast_q;

endmodule
`default_nettype wire
